>>> sv/nfcs_pkg.sv
// ----------------------------------------------------------------------------
// nfcs_pkg
// Shared types, codes and the bus cycle table of the NOR flash command
// sequencer.
// ----------------------------------------------------------------------------
package nfcs_pkg;

    localparam int ADDRESS_BITS = 20;
    localparam int DATA_BITS    = 16;
    localparam int STEP_BITS    = 3;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    // host command codes
    typedef enum logic [2:0] {
        CMD_READ     = 3'd0,
        CMD_PROGRAM  = 3'd1,
        CMD_ERASE    = 3'd2,
        CMD_ID_ENTRY = 3'd3,
        CMD_ID_EXIT  = 3'd4,
        CMD_POLL     = 3'd5
    } cmd_t;

    // flash bus cycle kinds
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_RESET  = 2'd2,
        OP_STATUS = 2'd3
    } bus_op_t;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_DONE   = 2'd1,
        ST_REJECT = 2'd2
    } status_t;

    // configuration register indexes
    localparam logic CFG_ID_EXIT_SUPPORTED = 1'b0;
    localparam logic CFG_DEVICE_IDENTIFIED = 1'b1;

    // sequences the back end knows how to play
    typedef enum logic [3:0] {
        JOB_READ,
        JOB_PROGRAM,
        JOB_ERASE,
        JOB_ID_ENTRY,
        JOB_ID_EXIT,
        JOB_RESET,
        JOB_REJECT,
        JOB_POLL_DONE,
        JOB_POLL_READ
    } job_kind_t;

    typedef struct packed {
        job_kind_t               kind;
        logic [ADDRESS_BITS-1:0] address;
        logic [DATA_BITS-1:0]    data;
    } job_t;

    typedef struct packed {
        bus_op_t                 op;
        logic [ADDRESS_BITS-1:0] address;
        logic [DATA_BITS-1:0]    data;
        status_t                 status;
        logic                    last;
    } result_t;

    localparam logic [ADDRESS_BITS-1:0] ADDR_5555 = ADDRESS_BITS'(16'h5555);
    localparam logic [ADDRESS_BITS-1:0] ADDR_2AAA = ADDRESS_BITS'(16'h2AAA);
    localparam logic [DATA_BITS-1:0]    DATA_AA   = DATA_BITS'(8'hAA);
    localparam logic [DATA_BITS-1:0]    DATA_55   = DATA_BITS'(8'h55);
    localparam logic [DATA_BITS-1:0]    DATA_A0   = DATA_BITS'(8'hA0);
    localparam logic [DATA_BITS-1:0]    DATA_80   = DATA_BITS'(8'h80);
    localparam logic [DATA_BITS-1:0]    DATA_30   = DATA_BITS'(8'h30);
    localparam logic [DATA_BITS-1:0]    DATA_90   = DATA_BITS'(8'h90);
    localparam logic [DATA_BITS-1:0]    DATA_F0   = DATA_BITS'(8'hF0);

    // bus cycle number 'step' of a job
    function automatic result_t seq_result(
        input job_kind_t               kind,
        input logic [STEP_BITS-1:0]    step,
        input logic [ADDRESS_BITS-1:0] addr,
        input logic [DATA_BITS-1:0]    data
    );
        result_t r;
        r.op      = OP_WRITE;
        r.address = '0;
        r.data    = '0;
        r.status  = ST_NONE;
        r.last    = 1'b0;
        case (kind)
            JOB_READ, JOB_POLL_READ:
            begin
                r.op      = OP_READ;
                r.address = addr;
                r.status  = (kind == JOB_READ) ? ST_DONE : ST_NONE;
                r.last    = 1'b1;
            end
            JOB_RESET:
            begin
                r.op     = OP_RESET;
                r.status = ST_DONE;
                r.last   = 1'b1;
            end
            JOB_REJECT:
            begin
                r.op     = OP_STATUS;
                r.status = ST_REJECT;
                r.last   = 1'b1;
            end
            JOB_POLL_DONE:
            begin
                r.op     = OP_STATUS;
                r.status = ST_DONE;
                r.last   = 1'b1;
            end
            JOB_ID_ENTRY, JOB_ID_EXIT:
            begin
                case (step)
                    3'd0:
                    begin
                        r.address = ADDR_5555;
                        r.data    = DATA_AA;
                    end
                    3'd1:
                    begin
                        r.address = ADDR_2AAA;
                        r.data    = DATA_55;
                    end
                    default:
                    begin
                        r.address = ADDR_5555;
                        r.data    = (kind == JOB_ID_ENTRY) ? DATA_90 : DATA_F0;
                        r.status  = ST_DONE;
                        r.last    = 1'b1;
                    end
                endcase
            end
            JOB_PROGRAM:
            begin
                case (step)
                    3'd0:
                    begin
                        r.address = ADDR_5555;
                        r.data    = DATA_AA;
                    end
                    3'd1:
                    begin
                        r.address = ADDR_2AAA;
                        r.data    = DATA_55;
                    end
                    3'd2:
                    begin
                        r.address = ADDR_5555;
                        r.data    = DATA_A0;
                    end
                    3'd3:
                    begin
                        r.address = addr;
                        r.data    = data;
                    end
                    default:
                    begin
                        r.op      = OP_READ;
                        r.address = addr;
                        r.last    = 1'b1;
                    end
                endcase
            end
            JOB_ERASE:
            begin
                case (step)
                    3'd0, 3'd3:
                    begin
                        r.address = ADDR_5555;
                        r.data    = DATA_AA;
                    end
                    3'd1, 3'd4:
                    begin
                        r.address = ADDR_2AAA;
                        r.data    = DATA_55;
                    end
                    3'd2:
                    begin
                        r.address = ADDR_5555;
                        r.data    = DATA_80;
                    end
                    3'd5:
                    begin
                        r.address = addr;
                        r.data    = DATA_30;
                    end
                    default:
                    begin
                        r.op      = OP_READ;
                        r.address = addr;
                        r.last    = 1'b1;
                    end
                endcase
            end
            default:
            begin
                r.op   = OP_STATUS;
                r.last = 1'b1;
            end
        endcase
        return r;
    endfunction

endpackage

>>> sv/nor_flash_command_sequencer_top.sv
// ----------------------------------------------------------------------------
// nor_flash_command_sequencer_top
// Host command to parallel NOR flash bus cycle sequencer.
// ----------------------------------------------------------------------------
// The front end takes one request per clock while its four-entry job queue
// has room, and it settles the polling state at once; the back end emits
// one bus cycle per clock from the queue head unless stalled: a read, reset
// pulse, status or rejected request is one bus cycle, ID entry and ID exit
// are three, program is five and sector erase is seven, so the sustained
// rate is set by the bus cycles per request and by how fast the flash side
// takes them off the output register. A poll sample request while polling
// yields a single result that ends polling or re-reads the target address.
module nor_flash_command_sequencer_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        command,
    input  logic [nfcs_pkg::ADDRESS_BITS-1:0] address,
    input  logic [nfcs_pkg::DATA_BITS-1:0]    data,
    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic                              cfg_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        bus_op,
    output logic [nfcs_pkg::ADDRESS_BITS-1:0] bus_address,
    output logic [nfcs_pkg::DATA_BITS-1:0]    bus_data,
    output logic [1:0]                        status,
    output logic                              last
);

    logic           queue_full;
    logic           queue_empty;
    logic           job_push;
    logic           job_pop;
    nfcs_pkg::job_t job_in;
    nfcs_pkg::job_t job_head;

    // request classification
    nfcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .address    (address),
        .data       (data),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .job_push   (job_push),
        .job        (job_in)
    );

    // job queue
    nfcs_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job_in),
        .full     (queue_full),
        .pop      (job_pop),
        .empty    (queue_empty),
        .head     (job_head)
    );

    // bus cycle sequencer
    nfcs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (queue_empty),
        .head        (job_head),
        .pop         (job_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bus_op      (bus_op),
        .bus_address (bus_address),
        .bus_data    (bus_data),
        .status      (status),
        .last        (last)
    );

endmodule

>>> sv/nfcs_front.sv
// ----------------------------------------------------------------------------
// nfcs_front
// Accepts host requests, tracks the polling state and turns a request into
// a job for the back end when it calls for one.
// ----------------------------------------------------------------------------
module nfcs_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [2:0]                       command,
    input  logic [nfcs_pkg::ADDRESS_BITS-1:0] address,
    input  logic [nfcs_pkg::DATA_BITS-1:0]    data,
    input  logic                             cfg_write,
    input  logic                             cfg_index,
    input  logic                             cfg_data,
    input  logic                             queue_full,
    output logic                             job_push,
    output nfcs_pkg::job_t                   job
);

    logic                              id_exit_supported_reg;
    logic                              device_identified_reg;
    logic                              poll_active_reg;
    logic                              poll_active_next;
    logic                              expected_dq7_reg;
    logic                              expected_dq7_next;
    logic [nfcs_pkg::ADDRESS_BITS-1:0] poll_address_reg;
    logic [nfcs_pkg::ADDRESS_BITS-1:0] poll_address_next;
    logic                              accept;
    logic                              has_job;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign job_push = accept && has_job;

    // classify the request against the current polling state
    always_comb
    begin
        has_job           = 1'b0;
        job.kind          = nfcs_pkg::JOB_READ;
        job.address       = address;
        job.data          = data;
        poll_active_next  = poll_active_reg;
        expected_dq7_next = expected_dq7_reg;
        poll_address_next = poll_address_reg;
        if (command == nfcs_pkg::CMD_POLL)
        begin
            if (poll_active_reg)
            begin
                has_job     = 1'b1;
                job.address = poll_address_reg;
                if (data[7] == expected_dq7_reg)
                begin
                    job.kind         = nfcs_pkg::JOB_POLL_DONE;
                    poll_active_next = 1'b0;
                end
                else
                begin
                    job.kind = nfcs_pkg::JOB_POLL_READ;
                end
            end
        end
        else if (command inside {nfcs_pkg::CMD_READ, nfcs_pkg::CMD_PROGRAM,
                                 nfcs_pkg::CMD_ERASE, nfcs_pkg::CMD_ID_ENTRY,
                                 nfcs_pkg::CMD_ID_EXIT})
        begin
            if (poll_active_reg)
            begin
                has_job  = 1'b1;
                job.kind = nfcs_pkg::JOB_REJECT;
            end
            else
            begin
                case (command)
                    nfcs_pkg::CMD_READ:
                    begin
                        has_job  = 1'b1;
                        job.kind = nfcs_pkg::JOB_READ;
                    end
                    nfcs_pkg::CMD_PROGRAM:
                    begin
                        has_job           = 1'b1;
                        job.kind          = nfcs_pkg::JOB_PROGRAM;
                        poll_active_next  = 1'b1;
                        expected_dq7_next = data[7];
                        poll_address_next = address;
                    end
                    nfcs_pkg::CMD_ERASE:
                    begin
                        has_job           = 1'b1;
                        job.kind          = nfcs_pkg::JOB_ERASE;
                        poll_active_next  = 1'b1;
                        expected_dq7_next = 1'b1;
                        poll_address_next = address;
                    end
                    nfcs_pkg::CMD_ID_ENTRY:
                    begin
                        has_job  = 1'b1;
                        job.kind = nfcs_pkg::JOB_ID_ENTRY;
                    end
                    default:
                    begin
                        has_job  = device_identified_reg;
                        job.kind = id_exit_supported_reg ? nfcs_pkg::JOB_ID_EXIT
                                                         : nfcs_pkg::JOB_RESET;
                    end
                endcase
            end
        end
    end

    // polling state, updated only on accepted requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_active_reg  <= 1'b0;
            expected_dq7_reg <= 1'b0;
            poll_address_reg <= '0;
        end
        else if (accept)
        begin
            poll_active_reg  <= poll_active_next;
            expected_dq7_reg <= expected_dq7_next;
            poll_address_reg <= poll_address_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_exit_supported_reg <= 1'b0;
            device_identified_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == nfcs_pkg::CFG_ID_EXIT_SUPPORTED)
            begin
                id_exit_supported_reg <= cfg_data;
            end
            else
            begin
                device_identified_reg <= cfg_data;
            end
        end
    end

endmodule

>>> sv/nfcs_fifo.sv
// ----------------------------------------------------------------------------
// nfcs_fifo
// Short job queue between the front end and the bus cycle sequencer.
// ----------------------------------------------------------------------------
module nfcs_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nfcs_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output nfcs_pkg::job_t head
);

    nfcs_pkg::job_t                 mem_reg [nfcs_pkg::FIFO_DEPTH];
    logic [nfcs_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [nfcs_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [nfcs_pkg::FIFO_AW:0]     count_reg;
    logic [nfcs_pkg::FIFO_AW:0]     count_next;

    assign full  = (count_reg == (nfcs_pkg::FIFO_AW + 1)'(nfcs_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> sv/nfcs_back.sv
// ----------------------------------------------------------------------------
// nfcs_back
// Plays the job at the queue head as flash bus cycles into an output register,
// one per clock while that register is not stalled.
// ----------------------------------------------------------------------------
module nfcs_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              empty,
    input  nfcs_pkg::job_t                    head,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        bus_op,
    output logic [nfcs_pkg::ADDRESS_BITS-1:0] bus_address,
    output logic [nfcs_pkg::DATA_BITS-1:0]    bus_data,
    output logic [1:0]                        status,
    output logic                              last
);

    logic [nfcs_pkg::STEP_BITS-1:0] step_reg;
    logic [nfcs_pkg::STEP_BITS-1:0] step_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    nfcs_pkg::result_t              res;
    nfcs_pkg::result_t              out_reg;
    logic                           load;

    assign res  = nfcs_pkg::seq_result(head.kind, step_reg, head.address, head.data);
    assign load = !empty && (!out_valid_reg || !out_stall);
    assign pop  = load && res.last;

    // step counter and output valid
    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
            step_next      = res.last ? '0 : step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign bus_op      = out_reg.op;
    assign bus_address = out_reg.address;
    assign bus_data    = out_reg.data;
    assign status      = out_reg.status;
    assign last        = out_reg.last;

endmodule
